// ===== rtl/apr_pkg.sv =====
package apr_pkg;

	localparam int COORD_WIDTH_DEF    = 32;
	localparam int AXIS_FRAC_BITS_DEF = 14;
	localparam int ANGLE_BITS_DEF     = 16;
	localparam int AXIS_WIDTH         = 16;

	// CORDIC datapath: x/y in Q2.30 with guard bits, z in 2^-32 turn
	localparam int CORDIC_ITERS = 28;
	localparam int CORDIC_XY_W  = 34;
	localparam int CORDIC_Z_W   = 33;
	localparam int TRIG_W       = 32;

	localparam logic signed [CORDIC_XY_W-1:0] CORDIC_X0 = 34'sh026DD3B6A;
	localparam logic signed [CORDIC_XY_W-1:0] TRIG_ONE  = 34'sh040000000;

	// Quadrant codes of the folded phase
	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	// Arctangent of 2^-i in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input int idx);
		logic [31:0] r;
		case (idx)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			24: r = 32'h00000029;
			25: r = 32'h00000014;
			26: r = 32'h0000000A;
			27: r = 32'h00000005;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/apr_cordic.sv =====
module apr_cordic import apr_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int SIDE_W     = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [ANGLE_BITS-1:0]    angle,
	input  logic [SIDE_W-1:0]        side_in,
	output logic                     out_valid,
	output logic signed [TRIG_W-1:0] cos_o,
	output logic signed [TRIG_W-1:0] sin_o,
	output logic [SIDE_W-1:0]        side_out
);

	logic [31:0] phase;
	logic                          v_s  [0:CORDIC_ITERS];
	logic signed [CORDIC_XY_W-1:0] x_s  [0:CORDIC_ITERS];
	logic signed [CORDIC_XY_W-1:0] y_s  [0:CORDIC_ITERS];
	logic signed [CORDIC_Z_W-1:0]  z_s  [0:CORDIC_ITERS];
	logic [1:0]                    q_s  [0:CORDIC_ITERS];
	logic [SIDE_W-1:0]             sd_s [0:CORDIC_ITERS];
	logic signed [CORDIC_XY_W-1:0] cc, ss;
	logic                          v_m_s;

	// Move the angle to the top of a 32-bit phase
	assign phase = {angle, {(32-ANGLE_BITS){1'b0}}};

	// Load the entry stage: quadrant split off, gain-compensated unit vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= CORDIC_X0;
			y_s[0]  <= '0;
			z_s[0]  <= $signed({3'b000, phase[29:0]});
			q_s[0]  <= phase[31:30];
			sd_s[0] <= side_in;
		end
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
		localparam logic signed [CORDIC_Z_W-1:0] ATAN = $signed({1'b0, atan_turn(i)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][CORDIC_Z_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN;
				end
				q_s[i+1]  <= q_s[i];
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	// Map back to the full circle by quadrant
	always_comb begin
		case (quad_t'(q_s[CORDIC_ITERS]))
			QUAD_0: begin
				cc = x_s[CORDIC_ITERS];
				ss = y_s[CORDIC_ITERS];
			end
			QUAD_1: begin
				cc = -y_s[CORDIC_ITERS];
				ss = x_s[CORDIC_ITERS];
			end
			QUAD_2: begin
				cc = -x_s[CORDIC_ITERS];
				ss = -y_s[CORDIC_ITERS];
			end
			default: begin
				cc = y_s[CORDIC_ITERS];
				ss = -x_s[CORDIC_ITERS];
			end
		endcase
	end

	// Clamp to plus or minus one and register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m_s <= 1'b0;
		end else if (en) begin
			v_m_s <= v_s[CORDIC_ITERS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (cc > TRIG_ONE) begin
				cos_o <= TRIG_W'(TRIG_ONE);
			end else if (cc < -TRIG_ONE) begin
				cos_o <= TRIG_W'(-TRIG_ONE);
			end else begin
				cos_o <= TRIG_W'(cc);
			end
			if (ss > TRIG_ONE) begin
				sin_o <= TRIG_W'(TRIG_ONE);
			end else if (ss < -TRIG_ONE) begin
				sin_o <= TRIG_W'(-TRIG_ONE);
			end else begin
				sin_o <= TRIG_W'(ss);
			end
			side_out <= sd_s[CORDIC_ITERS];
		end
	end

	assign out_valid = v_m_s;

endmodule

// ===== rtl/axis_angle_point_rotation.sv =====
// Axis-angle point rotation, fully pipelined.
// Pipeline: 30 CORDIC stages, then 5 matrix stages, from input request to result.
// Throughput: one request per cycle; the whole pipe holds while the result is not taken.
// Reset: arst_n clears all valid bits asynchronously; payload registers are not reset.
module axis_angle_point_rotation import apr_pkg::*; #(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int AXIS_FRAC_BITS = AXIS_FRAC_BITS_DEF,
	parameter int ANGLE_BITS     = ANGLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] in_x,
	input  logic signed [COORD_WIDTH-1:0] in_y,
	input  logic signed [COORD_WIDTH-1:0] in_z,
	input  logic signed [AXIS_WIDTH-1:0]  axis_x,
	input  logic signed [AXIS_WIDTH-1:0]  axis_y,
	input  logic signed [AXIS_WIDTH-1:0]  axis_z,
	input  logic [ANGLE_BITS-1:0]         angle,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic signed [COORD_WIDTH-1:0] out_z
);

	localparam int CW     = COORD_WIDTH;
	localparam int F      = AXIS_FRAC_BITS;
	localparam int SIDE_W = 3*CW + 3*AXIS_WIDTH;
	localparam int NN_W   = 2*AXIS_WIDTH;
	localparam int T_W    = TRIG_W + 1;
	localparam int NT_W   = NN_W + T_W + 1;
	localparam int NS_W   = AXIS_WIDTH + TRIG_W + 1;
	localparam int E1     = NT_W - 2*F;
	localparam int E2     = NS_W - F;
	localparam int E12    = (E1 > E2) ? E1 : E2;
	localparam int ENT_W  = (E12 > TRIG_W + 1) ? E12 : TRIG_W + 1;
	localparam int M_W    = ENT_W + 1;
	localparam int P_W    = CW + M_W;
	localparam int S_W    = P_W + 2;
	localparam int V_W    = S_W - 30;

	localparam logic signed [NT_W-1:0] HALF_NT = NT_W'(1) <<< (2*F - 1);
	localparam logic signed [NS_W-1:0] HALF_NS = NS_W'(1) <<< (F - 1);
	localparam logic signed [S_W-1:0]  HALF_S  = S_W'(1) <<< 29;
	localparam logic signed [V_W-1:0]  CMAX = {{(V_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [V_W-1:0]  CMIN = {{(V_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

	logic en;
	logic                     c_valid;
	logic signed [TRIG_W-1:0] c_cos, c_sin;
	logic [SIDE_W-1:0]        c_side;

	logic signed [CW-1:0]         px, py, pz;
	logic signed [AXIS_WIDTH-1:0] nx, ny, nz;

	// Stall the whole pipe only when a finished result waits
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	apr_cordic #(
		.ANGLE_BITS (ANGLE_BITS),
		.SIDE_W     (SIDE_W)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.angle     (angle),
		.side_in   ({in_x, in_y, in_z, axis_x, axis_y, axis_z}),
		.out_valid (c_valid),
		.cos_o     (c_cos),
		.sin_o     (c_sin),
		.side_out  (c_side)
	);

	assign {px, py, pz, nx, ny, nz} = c_side;

	// Stage 1: axis products, 1 - cos, axis times sin
	logic                     v_s1;
	logic signed [NN_W-1:0]   nxx_s1, nyy_s1, nzz_s1, nxy_s1, nxz_s1, nyz_s1;
	logic signed [NS_W-1:0]   nsx_s1, nsy_s1, nsz_s1;
	logic signed [T_W-1:0]    t_s1;
	logic signed [TRIG_W-1:0] c_s1;
	logic signed [CW-1:0]     px_s1, py_s1, pz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			nxx_s1 <= nx * nx;
			nyy_s1 <= ny * ny;
			nzz_s1 <= nz * nz;
			nxy_s1 <= nx * ny;
			nxz_s1 <= nx * nz;
			nyz_s1 <= ny * nz;
			nsx_s1 <= NS_W'(nx) * NS_W'(c_sin);
			nsy_s1 <= NS_W'(ny) * NS_W'(c_sin);
			nsz_s1 <= NS_W'(nz) * NS_W'(c_sin);
			t_s1   <= T_W'(TRIG_ONE) - T_W'(c_cos);
			c_s1   <= c_cos;
			px_s1  <= px;
			py_s1  <= py;
			pz_s1  <= pz;
		end
	end

	// Stage 2: scale axis products by 1 - cos, round all entries
	logic                     v_s2;
	logic signed [NT_W-1:0]   nt_xx, nt_yy, nt_zz, nt_xy, nt_xz, nt_yz;
	logic signed [ENT_W-1:0]  axx_s2, ayy_s2, azz_s2, axy_s2, axz_s2, ayz_s2;
	logic signed [ENT_W-1:0]  sx_s2, sy_s2, sz_s2;
	logic signed [TRIG_W-1:0] c_s2;
	logic signed [CW-1:0]     px_s2, py_s2, pz_s2;

	assign nt_xx = NT_W'(nxx_s1) * NT_W'(t_s1);
	assign nt_yy = NT_W'(nyy_s1) * NT_W'(t_s1);
	assign nt_zz = NT_W'(nzz_s1) * NT_W'(t_s1);
	assign nt_xy = NT_W'(nxy_s1) * NT_W'(t_s1);
	assign nt_xz = NT_W'(nxz_s1) * NT_W'(t_s1);
	assign nt_yz = NT_W'(nyz_s1) * NT_W'(t_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			axx_s2 <= ENT_W'((nt_xx + HALF_NT) >>> (2*F));
			ayy_s2 <= ENT_W'((nt_yy + HALF_NT) >>> (2*F));
			azz_s2 <= ENT_W'((nt_zz + HALF_NT) >>> (2*F));
			axy_s2 <= ENT_W'((nt_xy + HALF_NT) >>> (2*F));
			axz_s2 <= ENT_W'((nt_xz + HALF_NT) >>> (2*F));
			ayz_s2 <= ENT_W'((nt_yz + HALF_NT) >>> (2*F));
			sx_s2  <= ENT_W'((nsx_s1 + HALF_NS) >>> F);
			sy_s2  <= ENT_W'((nsy_s1 + HALF_NS) >>> F);
			sz_s2  <= ENT_W'((nsz_s1 + HALF_NS) >>> F);
			c_s2   <= c_s1;
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			pz_s2  <= pz_s1;
		end
	end

	// Stage 3: assemble the rotation matrix
	logic                   v_s3;
	logic signed [M_W-1:0]  m_s3 [0:8];
	logic signed [ENT_W-1:0] c_e;
	logic signed [CW-1:0]   px_s3, py_s3, pz_s3;

	assign c_e = ENT_W'(c_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			m_s3[0] <= M_W'(c_e) + M_W'(axx_s2);
			m_s3[1] <= M_W'(axy_s2) - M_W'(sz_s2);
			m_s3[2] <= M_W'(axz_s2) + M_W'(sy_s2);
			m_s3[3] <= M_W'(axy_s2) + M_W'(sz_s2);
			m_s3[4] <= M_W'(c_e) + M_W'(ayy_s2);
			m_s3[5] <= M_W'(ayz_s2) - M_W'(sx_s2);
			m_s3[6] <= M_W'(axz_s2) - M_W'(sy_s2);
			m_s3[7] <= M_W'(ayz_s2) + M_W'(sx_s2);
			m_s3[8] <= M_W'(c_e) + M_W'(azz_s2);
			px_s3   <= px_s2;
			py_s3   <= py_s2;
			pz_s3   <= pz_s2;
		end
	end

	// Stage 4: coordinate times matrix entry
	logic                  v_s4;
	logic signed [P_W-1:0] p_s4 [0:8];

	for (genvar r = 0; r < 3; r++) begin : g_row
		always_ff @(posedge clk) begin
			if (en) begin
				p_s4[3*r]   <= P_W'(px_s3) * P_W'(m_s3[3*r]);
				p_s4[3*r+1] <= P_W'(py_s3) * P_W'(m_s3[3*r+1]);
				p_s4[3*r+2] <= P_W'(pz_s3) * P_W'(m_s3[3*r+2]);
			end
		end
	end

	// Stage 5: row sums, round, saturate into the output register
	logic signed [S_W-1:0] sum [0:2];
	logic signed [V_W-1:0] vr  [0:2];
	logic signed [CW-1:0]  sat [0:2];

	for (genvar r = 0; r < 3; r++) begin : g_sum
		assign sum[r] = S_W'(p_s4[3*r]) + S_W'(p_s4[3*r+1]) + S_W'(p_s4[3*r+2]) + HALF_S;
		assign vr[r]  = V_W'(sum[r] >>> 30);
		assign sat[r] = (vr[r] > CMAX) ? CW'(CMAX) :
				(vr[r] < CMIN) ? CW'(CMIN) : CW'(vr[r]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_x <= sat[0];
			out_y <= sat[1];
			out_z <= sat[2];
		end
	end

	// Advance valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= c_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= v_s4;
		end
	end

	// A held result freezes the pipe behind it
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(v_s4) && $stable(p_s4[0]) && $stable(v_s1))
		else $error("pipeline moved while the result was held");

	// A new result only appears after the pipe advanced
	a_new_after_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s4) && $past(en))
		else $error("result appeared without an advancing stage");

endmodule

// ===== tb/sv/tb_axis_angle_point_rotation.sv =====
module tb_axis_angle_point_rotation import apr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 60;
	localparam longint COORD_MAX = 64'sd2147483647;
	localparam longint COORD_MIN = -64'sd2147483648;

	typedef struct {
		logic signed [31:0] px, py, pz;
		logic signed [15:0] nx, ny, nz;
		logic [15:0]        ang;
		bit                 fixed_exp;
		logic signed [31:0] ex, ey, ez;
	} rot_req_t;

	typedef struct {
		logic signed [31:0] x, y, z;
	} point_t;

	// arctangent of 2^-i, 2^-32 turn units
	localparam longint ATAN_TBL [CORDIC_ITERS] = '{
		'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
		'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
		'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
		'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
		'h00000029, 'h00000014, 'h0000000A, 'h00000005
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
	logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0;
	logic [15:0]        angle = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] out_x, out_y, out_z;

	rot_req_t req_q[$];
	rot_req_t cur_req;
	point_t   rotated_q[$];
	int       errors = 0;
	int       cycles = 0;
	bit       run = 1'b0;
	int       gap_left = 0;
	int       burst_left = 0;
	int       stall_mode = 0;
	int       stall_cnt = 0;

	axis_angle_point_rotation dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_x(in_x), .in_y(in_y), .in_z(in_z),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .angle(angle),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_z(out_z)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// cos/sin of a binary angle, Q2.30, by first-quadrant CORDIC
	function automatic void cordic_sin_cos(input logic [15:0] ang, output longint c,
			output longint s);
		logic [31:0] phase;
		longint x, y, z, dx, dy;
		quad_t q;
		phase = {ang, 16'h0000};
		q = quad_t'(phase[31:30]);
		z = longint'(phase[29:0]);
		x = 64'h26DD3B6A;
		y = 0;
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TBL[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TBL[i];
			end
		end
		case (q)
			QUAD_0: begin c = x;  s = y;  end
			QUAD_1: begin c = -y; s = x;  end
			QUAD_2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		if (c > (64'sd1 << 30)) c = 64'sd1 << 30;
		if (c < -(64'sd1 << 30)) c = -(64'sd1 << 30);
		if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
		if (s < -(64'sd1 << 30)) s = -(64'sd1 << 30);
	endfunction

	function automatic longint round_sr(input longint v, input int sh);
		return (v + (64'sd1 << (sh - 1))) >>> sh;
	endfunction

	// one output coordinate: exact dot product, round half up, saturate
	function automatic logic signed [31:0] dot_row(input longint px, py, pz,
			input longint m0, m1, m2);
		logic signed [127:0] a0, a1, a2, b0, b1, b2, acc;
		a0 = px; a1 = py; a2 = pz;
		b0 = m0; b1 = m1; b2 = m2;
		acc = a0 * b0 + a1 * b1 + a2 * b2 + (128'sd1 <<< 29);
		acc = acc >>> 30;
		if (acc > COORD_MAX) return 32'sh7FFFFFFF;
		if (acc < COORD_MIN) return 32'sh80000000;
		return acc[31:0];
	endfunction

	function automatic point_t rotate_point(input rot_req_t r);
		longint c, s, t, nx, ny, nz;
		longint axx, ayy, azz, axy, axz, ayz, sx, sy, sz;
		point_t p;
		cordic_sin_cos(r.ang, c, s);
		nx = r.nx; ny = r.ny; nz = r.nz;
		t = (64'sd1 << 30) - c;
		axx = round_sr(nx * nx * t, 2 * AXIS_FRAC_BITS_DEF);
		ayy = round_sr(ny * ny * t, 2 * AXIS_FRAC_BITS_DEF);
		azz = round_sr(nz * nz * t, 2 * AXIS_FRAC_BITS_DEF);
		axy = round_sr(nx * ny * t, 2 * AXIS_FRAC_BITS_DEF);
		axz = round_sr(nx * nz * t, 2 * AXIS_FRAC_BITS_DEF);
		ayz = round_sr(ny * nz * t, 2 * AXIS_FRAC_BITS_DEF);
		sx = round_sr(nx * s, AXIS_FRAC_BITS_DEF);
		sy = round_sr(ny * s, AXIS_FRAC_BITS_DEF);
		sz = round_sr(nz * s, AXIS_FRAC_BITS_DEF);
		p.x = dot_row(r.px, r.py, r.pz, c + axx, axy - sz, axz + sy);
		p.y = dot_row(r.px, r.py, r.pz, axy + sz, c + ayy, ayz - sx);
		p.z = dot_row(r.px, r.py, r.pz, axz - sy, ayz + sx, c + azz);
		return p;
	endfunction

	function automatic rot_req_t mk(input logic signed [31:0] px, py, pz,
			input logic signed [15:0] nx, ny, nz, input logic [15:0] ang);
		rot_req_t r;
		r = '{px, py, pz, nx, ny, nz, ang, 1'b0, 0, 0, 0};
		return r;
	endfunction

	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 16'sh4000;
			1: return -16'sh4000;
			2: return 16'sh8000;
			3: return 16'sh0000;
			4: return 16'($urandom());
			default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: return $signed(32'($urandom_range(0, 1 << 24))) - 32'sd8388608;
		endcase
	endfunction

	// drive requests in bursts with random gaps; predict on acceptance
	always @(posedge clk) begin
		if (run) begin
			if (in_valid && in_ready) begin
				if (cur_req.fixed_exp)
					rotated_q.push_back('{cur_req.ex, cur_req.ey, cur_req.ez});
				else
					rotated_q.push_back(rotate_point(cur_req));
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || req_q.size() == 0) begin
					if (gap_left > 0) gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else begin
					cur_req = req_q.pop_front();
					in_x <= cur_req.px; in_y <= cur_req.py; in_z <= cur_req.pz;
					axis_x <= cur_req.nx; axis_y <= cur_req.ny; axis_z <= cur_req.nz;
					angle <= cur_req.ang;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// stall the result side; the mode is redrawn each time stall_cnt wraps
	always @(posedge clk) begin
		if (run) begin
			if (stall_cnt == 49) begin
				stall_cnt <= 0;
				stall_mode <= $urandom_range(0, 3);
			end else begin
				stall_cnt <= stall_cnt + 1;
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= (stall_cnt % 4 == 0);
				default: out_ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// compare each taken result with the oldest prediction
	always @(posedge clk) begin
		point_t e;
		if (out_valid && out_ready) begin
			if (rotated_q.size() == 0) begin
				$display("%0t unexpected result x=%0d y=%0d z=%0d", $time, out_x, out_y, out_z);
				errors++;
			end else begin
				e = rotated_q.pop_front();
				if (out_x !== e.x) begin
					$display("%0t out_x expected %0d got %0d", $time, e.x, out_x);
					errors++;
				end
				if (out_y !== e.y) begin
					$display("%0t out_y expected %0d got %0d", $time, e.y, out_y);
					errors++;
				end
				if (out_z !== e.z) begin
					$display("%0t out_z expected %0d got %0d", $time, e.z, out_z);
					errors++;
				end
			end
		end
	end

	// abort on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[axis_angle_point_rotation] ERROR");
			$finish;
		end
	end

	initial begin
		rot_req_t tbl [];
		rot_req_t r;
		tbl = new[17];
		// zero point stays at the origin
		tbl[0] = mk(0, 0, 0, 0, 0, 16'sh4000, 16'h4000);
		tbl[0].fixed_exp = 1'b1;
		// axis -32768 at a half turn scales x by seven: saturate high, then low
		tbl[1] = mk(32'sh7FFFFFFF, 0, 0, 16'sh8000, 0, 0, 16'h8000);
		tbl[1].fixed_exp = 1'b1;
		tbl[1].ex = 32'sh7FFFFFFF;
		tbl[2] = mk(32'sh80000000, 0, 0, 16'sh8000, 0, 0, 16'h8000);
		tbl[2].fixed_exp = 1'b1;
		tbl[2].ex = 32'sh80000000;
		tbl[3] = mk(32'sh00010000, 32'sh00020000, 32'sh00030000, 16'sh4000, 0, 0, 16'h0000);
		tbl[4] = mk(32'sh00010000, 32'sh00020000, 32'sh00030000, 0, 0, 16'sh4000, 16'h4000);
		tbl[5] = mk(32'sh00010000, 32'sh00020000, 32'sh00030000, 0, 0, 16'sh4000, 16'h8000);
		tbl[6] = mk(32'sh00010000, 32'sh00020000, 32'sh00030000, 0, 0, 16'sh4000, 16'hC000);
		tbl[7] = mk(32'sh00010000, -32'sh00020000, 32'sh00030000, 0, 16'sh4000, 0, 16'hFFFF);
		tbl[8] = mk(32'sh00010000, 32'sh00020000, 32'sh00030000, 16'sh4000, 0, 0, 16'h0001);
		tbl[9] = mk(32'sh00050000, 32'sh00060000, -32'sh00070000, 0, 0, 0, 16'h2000);
		tbl[10] = mk(32'sh00050000, 32'sh00060000, 32'sh00070000,
			16'sd10000, 16'sd10000, 16'sd10000, 16'h2AAA);
		tbl[11] = mk(32'sh12345678, -32'sh0ABCDEF0, 32'sh00FF00FF,
			16'sh8000, 16'sh8000, 16'sh8000, 16'h5555);
		tbl[12] = mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 16'sh4000, 0, 16'h3FFF);
		tbl[13] = mk(32'sh80000000, 32'sh80000000, 32'sh80000000,
			-16'sh4000, 0, 0, 16'h7FFF);
		tbl[14] = mk(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
			16'sh4000, -16'sh4000, 16'sh4000, 16'hC000);
		tbl[15] = mk(-32'sh00000001, 32'sh00000001, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h8001);
		tbl[16] = mk(32'sh00008000, 32'sh00008000, 32'sh00008000,
			16'sh2D41, 16'sh2D41, 0, 16'h1000);
		foreach (tbl[i]) req_q.push_back(tbl[i]);
		// random requests: mostly near-unit axes and moderate points
		for (int i = 0; i < 450; i++) begin
			r = mk(rand_coord(), rand_coord(), rand_coord(),
				rand_axis(), rand_axis(), rand_axis(), 16'($urandom()));
			if ($urandom_range(0, 5) == 0)
				r.ang = {$urandom_range(0, 3) == 0 ? 2'b00 : 2'($urandom()), 14'h0000}
					+ 16'($urandom_range(0, 2)) - 16'd1;
			req_q.push_back(r);
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		run <= 1'b1;
		// wait until every request is sent, taken and its result checked
		@(negedge clk);
		while (req_q.size() != 0 || in_valid || rotated_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[axis_angle_point_rotation] OK");
		else
			$display("[axis_angle_point_rotation] ERROR");
		$finish;
	end

endmodule
